/* src/fpba_pkg.sv */
// Shared types and codes for the fit-policy block allocator.
// No dependencies; used by the top level, fpba_cmp and the testbench.
package fpba_pkg;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } t_state;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic CFG_FIT_MODE = 1'b0;
    localparam logic CFG_BLOCKS   = 1'b1;

    localparam int CFG_DATA_W     = 5;
    localparam int BLOCKS_RESET   = 16;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;   // any accepted input beat; starts a new search
        logic sample;  // read data of one entry is present this cycle
    } t_cmp_ctrl;

endpackage

/* src/fit_policy_block_allocator_top.sv */
// Top level of the fit-policy block allocator: sequencer, config registers,
// output register. Depends on fpba_pkg, fpba_ram and fpba_cmp.
//
// A load beat writes one table entry. An allocate beat searches n entries,
// n being blocks_in_use capped at NUM_BLOCKS: the sequencer reads one entry
// per cycle from the size table RAM through its single read port, the
// shared compare unit checks each one in the cycle after its read, and the UPDATE
// state writes the reduced size back and loads the result register. The input
// side stalls while an allocate is in progress; a result waiting in the output
// register only holds up the write-back of the next allocate, not loads. Table
// entries hold no reset value and must be loaded before they take part in a
// search.
module fit_policy_block_allocator_top #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [3:0]                    i_load_index,
    input  logic [15:0]                   i_size_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_granted,
    output logic [3:0]                    o_chosen_block,
    output logic [15:0]                   o_remaining_after,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    fpba_pkg::t_state    r_state, n_state;
    fpba_pkg::t_fit_mode r_fit_mode;
    logic [4:0]          r_blocks;
    logic [IDX_W-1:0]    r_next_start;
    logic [SIZE_BITS-1:0] r_req;
    logic [CNT_W-1:0]    r_n;
    logic [IDX_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_issued;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_out_valid;
    logic                r_out_granted;
    logic [3:0]          r_out_block;
    logic [15:0]         r_out_rem;

    logic                w_accept;
    logic                w_load_ok;
    logic [SIZE_BITS-1:0] w_size;
    logic [31:0]         w_size_ext;
    logic [CNT_W-1:0]    w_n;
    logic [IDX_W-1:0]    w_start;
    logic [CNT_W-1:0]    w_issued_inc;
    logic                w_issue;
    logic                w_commit;
    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    logic [SIZE_BITS-1:0] w_ram_wdata;
    logic [SIZE_BITS-1:0] w_rdata;
    logic [SIZE_BITS-1:0] w_diff;
    logic [31:0]         w_diff_ext;
    logic [31:0]         w_best_idx_ext;
    fpba_pkg::t_cmp_ctrl w_cmp_ctrl;
    logic                w_found;
    logic [IDX_W-1:0]    w_best_idx;
    logic [SIZE_BITS-1:0] w_best_val;

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_size_ext   = {16'b0, i_size_value};
    assign w_size       = w_size_ext[SIZE_BITS-1:0];
    assign w_load_ok    = (32'(i_load_index) < NUM_BLOCKS);
    assign w_n          = (32'(r_blocks) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(r_blocks);
    assign w_start      = (r_fit_mode == fpba_pkg::FIT_NEXT &&
                           32'(r_next_start) < 32'(w_n)) ? r_next_start : '0;
    assign w_issued_inc = r_issued + CNT_W'(1);
    assign w_diff       = w_best_val - r_req;
    assign w_diff_ext   = 32'(w_diff);
    assign w_best_idx_ext = 32'(w_best_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpba_pkg::ST_IDLE: begin
                if (w_accept && i_op == fpba_pkg::OP_ALLOC) begin
                    n_state = (w_n == '0) ? fpba_pkg::ST_UPDATE : fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN: begin
                if (w_issued_inc == r_n) begin
                    n_state = fpba_pkg::ST_LAST;
                end
            end
            fpba_pkg::ST_LAST:   n_state = fpba_pkg::ST_UPDATE;
            fpba_pkg::ST_UPDATE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_state = fpba_pkg::ST_IDLE;
                end
            end
            default: n_state = fpba_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall  = 1'b1;
        w_issue     = 1'b0;
        w_commit    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = w_best_idx;
        w_ram_wdata = w_diff;
        case (r_state)
            fpba_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_ram_we    = w_accept && i_op == fpba_pkg::OP_LOAD && w_load_ok;
                w_ram_waddr = IDX_W'(i_load_index);
                w_ram_wdata = w_size;
            end
            fpba_pkg::ST_SCAN: w_issue = 1'b1;
            fpba_pkg::ST_UPDATE: begin
                w_commit = !(r_out_valid && i_out_stall);
                w_ram_we = w_commit && w_found;
            end
            default: ;
        endcase
        w_cmp_ctrl.clear  = w_accept;
        w_cmp_ctrl.sample = r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fpba_pkg::ST_IDLE;
            r_fit_mode   <= fpba_pkg::FIT_FIRST;
            r_blocks     <= 5'(fpba_pkg::BLOCKS_RESET);
            r_next_start <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fpba_pkg::CFG_FIT_MODE: r_fit_mode <= fpba_pkg::t_fit_mode'(i_cfg_data[1:0]);
                    fpba_pkg::CFG_BLOCKS:   r_blocks   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept && i_op == fpba_pkg::OP_LOAD && w_load_ok) begin
                r_next_start <= '0;
            end else if (w_commit && w_found && r_fit_mode == fpba_pkg::FIT_NEXT) begin
                r_next_start <= w_best_idx;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan pointers and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= w_size;
            r_n      <= w_n;
            r_addr   <= w_start;
            r_issued <= '0;
        end else if (w_issue) begin
            r_rd_idx <= r_addr;
            r_addr   <= (32'(r_addr) + 32'd1 == 32'(r_n)) ? '0 : r_addr + IDX_W'(1);
            r_issued <= w_issued_inc;
        end
        if (w_commit) begin
            r_out_granted <= w_found;
            r_out_block   <= w_found ? w_best_idx_ext[3:0] : 4'd0;
            r_out_rem     <= w_found ? w_diff_ext[15:0] : 16'd0;
        end
    end

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    fpba_cmp #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_cmp_ctrl),
        .i_mode     (r_fit_mode),
        .i_req      (r_req),
        .i_value    (w_rdata),
        .i_idx      (r_rd_idx),
        .o_found    (w_found),
        .o_best_idx (w_best_idx),
        .o_best_val (w_best_val)
    );

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_granted         = r_out_granted;
    assign o_chosen_block    = r_out_block;
    assign o_remaining_after = r_out_rem;

endmodule

/* src/fpba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fpba_cmp.sv */
// Shared compare unit: checks one entry per cycle against the request and
// keeps the current candidate. Depends on fpba_pkg.
module fpba_cmp #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpba_pkg::t_cmp_ctrl  i_ctrl,
    input  fpba_pkg::t_fit_mode  i_mode,
    input  logic [SIZE_BITS-1:0] i_req,
    input  logic [SIZE_BITS-1:0] i_value,
    input  logic [IDX_W-1:0]     i_idx,
    output logic                 o_found,
    output logic [IDX_W-1:0]     o_best_idx,
    output logic [SIZE_BITS-1:0] o_best_val
);

    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_val;
    logic                 w_fits;
    logic                 w_better;
    logic                 w_take;

    always_comb begin
        w_fits = (i_value >= i_req);
        case (i_mode)
            fpba_pkg::FIT_BEST:  w_better = (i_value < r_best_val);
            fpba_pkg::FIT_WORST: w_better = (i_value > r_best_val);
            default:             w_better = 1'b0;  // first fitting entry in scan order
        endcase
        w_take = i_ctrl.sample && w_fits && (!r_found || w_better);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !i_ctrl.clear) begin
            r_best_idx <= i_idx;
            r_best_val <= i_value;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;
    assign o_best_val = r_best_val;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for fit_policy_block_allocator_top: a directed table, then random phases,
// with every allocate result checked against an in-bench model of the size table
// or, for typed rows, against the row's result. Depends on fpba_pkg and the allocator RTL.
module tb;

    localparam int NUM_BLOCKS     = 16;
    localparam int SETTLE_CYCLES  = NUM_BLOCKS + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int DIR_ROWS       = 26;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] remaining_after;
    } t_grant;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_ALLOC,
        ROW_CFG
    } t_row_kind;

    // ROW_CFG: idx holds the register index, value the write data.
    typedef struct packed {
        t_row_kind   kind;
        logic [3:0]  idx;
        logic [15:0] value;
        logic        typed;
        t_grant      res;
    } t_dir_row;

    localparam t_grant NO_GRANT = '0;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        i_op              = fpba_pkg::OP_LOAD;
    logic [3:0]  i_load_index      = '0;
    logic [15:0] i_size_value      = '0;
    logic        i_out_stall       = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic        i_cfg_index       = fpba_pkg::CFG_FIT_MODE;
    logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_granted;
    logic [3:0]  o_chosen_block;
    logic [15:0] o_remaining_after;
    logic        o_cfg_ready;

    // Model state
    logic [15:0]         size_table [NUM_BLOCKS];
    logic [3:0]          scan_ptr;
    fpba_pkg::t_fit_mode mode_reg;
    logic [4:0]          blocks_reg;

    t_grant pending_grants [$];
    logic   use_typed   = 1'b0;
    t_grant typed_grant = NO_GRANT;
    int     mismatches  = 0;
    int     idle_cycles = 0;
    int     stall_pct   = 30;
    int     stall_run   = 0;
    bit     stall_now   = 1'b0;

    // Preload puts (i + 1) * 100 in entry i before the table runs.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_LOAD,  4'd15, 16'hFFFF, 1'b0, NO_GRANT},
        '{ROW_LOAD,  4'd0,  16'h0000, 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'hA,  16'h0000, 1'b1, '{1'b1, 4'd0, 16'd0}},
        '{ROW_ALLOC, 4'h5,  16'hFFFF, 1'b1, '{1'b1, 4'd15, 16'd0}},
        '{ROW_ALLOC, 4'hF,  16'hFFFF, 1'b1, NO_GRANT},
        '{ROW_ALLOC, 4'h3,  16'd250,  1'b0, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_FIT_MODE), 16'(fpba_pkg::FIT_NEXT), 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h0,  16'd150,  1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'hC,  16'd150,  1'b0, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_FIT_MODE), 16'(fpba_pkg::FIT_BEST), 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h9,  16'd40,   1'b0, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_FIT_MODE), 16'(fpba_pkg::FIT_WORST), 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h6,  16'd1,    1'b0, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_BLOCKS), 16'd1, 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h1,  16'd1,    1'b1, NO_GRANT},
        '{ROW_ALLOC, 4'h2,  16'd0,    1'b1, '{1'b1, 4'd0, 16'd0}},
        '{ROW_CFG, 4'(fpba_pkg::CFG_BLOCKS), 16'd0, 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h7,  16'd0,    1'b1, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_BLOCKS), 16'd31, 1'b0, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_FIT_MODE), 16'(fpba_pkg::FIT_NEXT), 1'b0, NO_GRANT},
        // pointer sits past the searched entries, so the scan restarts at 0
        '{ROW_CFG, 4'(fpba_pkg::CFG_BLOCKS), 16'd2, 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h8,  16'd5,    1'b0, NO_GRANT},
        '{ROW_CFG, 4'(fpba_pkg::CFG_BLOCKS), 16'd31, 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'hB,  16'd5,    1'b0, NO_GRANT},
        '{ROW_LOAD,  4'd7,  16'h5A5A, 1'b0, NO_GRANT},
        '{ROW_ALLOC, 4'h4,  16'hA5A5, 1'b0, NO_GRANT}
    };

    fit_policy_block_allocator_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_load_index      (i_load_index),
        .i_size_value      (i_size_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_granted         (o_granted),
        .o_chosen_block    (o_chosen_block),
        .o_remaining_after (o_remaining_after),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one accepted beat to the model; the return value matters for allocates only.
    function automatic t_grant predict_grant(input logic op, input logic [3:0] idx,
                                             input logic [15:0] size);
        t_grant r;
        int     n;
        int     pick;
        int     pos;
        int     i;
        bit     done;
        r = NO_GRANT;
        if (op == fpba_pkg::OP_LOAD) begin
            size_table[idx] = size;
            scan_ptr = '0;
        end else begin
            n = (blocks_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_reg);
            pick = n;
            if (mode_reg == fpba_pkg::FIT_NEXT) begin
                pos = (scan_ptr < n) ? int'(scan_ptr) : 0;
                for (i = 0; i < n && pick == n; i++) begin
                    if (size_table[pos] >= size)
                        pick = pos;
                    else
                        pos = (pos + 1 == n) ? 0 : pos + 1;
                end
            end else begin
                done = 1'b0;
                for (i = 0; i < n && !done; i++) begin
                    if (size_table[i] >= size) begin
                        if (pick == n) begin
                            pick = i;
                            done = (mode_reg == fpba_pkg::FIT_FIRST);
                        end else if (mode_reg == fpba_pkg::FIT_BEST &&
                                     size_table[i] < size_table[pick]) begin
                            pick = i;
                        end else if (mode_reg == fpba_pkg::FIT_WORST &&
                                     size_table[i] > size_table[pick]) begin
                            pick = i;
                        end
                    end
                end
            end
            if (pick < n) begin
                size_table[pick] = size_table[pick] - size;
                if (mode_reg == fpba_pkg::FIT_NEXT)
                    scan_ptr = pick[3:0];
                r = '{1'b1, pick[3:0], size_table[pick]};
            end
        end
        return r;
    endfunction

    task automatic push_item(input logic op, input logic [3:0] idx, input logic [15:0] size,
                             input logic typed, input t_grant res);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_load_index <= idx;
        i_size_value <= size;
        use_typed    = typed;
        typed_grant  = res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic hold_input(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending, wait out every pending result, then the given extra cycles.
    task automatic drain(input int extra);
        hold_input(1);
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [fpba_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall runs of random length.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_now = ($urandom_range(0, 99) < stall_pct);
            stall_run = $urandom_range(1, stall_now ? 20 : 10);
        end
        stall_run = stall_run - 1;
        i_out_stall <= stall_now;
    end

    always @(posedge i_clk) begin : monitor
        t_grant got;
        t_grant want;
        t_grant predicted;
        bit     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got = '{o_granted, o_chosen_block, o_remaining_after};
                if (pending_grants.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none pending, expected nothing, actual %0b/%0d/%0d",
                             $time, got.granted, got.chosen_block, got.remaining_after);
                end else begin
                    want = pending_grants.pop_front();
                    if (got.granted !== want.granted) begin
                        mismatches++;
                        $display("%0t: granted expected %0b actual %0b",
                                 $time, want.granted, got.granted);
                    end
                    if (got.chosen_block !== want.chosen_block) begin
                        mismatches++;
                        $display("%0t: chosen_block expected %0d actual %0d",
                                 $time, want.chosen_block, got.chosen_block);
                    end
                    if (got.remaining_after !== want.remaining_after) begin
                        mismatches++;
                        $display("%0t: remaining_after expected %0d actual %0d",
                                 $time, want.remaining_after, got.remaining_after);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index == fpba_pkg::CFG_FIT_MODE)
                    mode_reg = fpba_pkg::t_fit_mode'(i_cfg_data[1:0]);
                else
                    blocks_reg = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                predicted = predict_grant(i_op, i_load_index, i_size_value);
                if (i_op == fpba_pkg::OP_ALLOC)
                    pending_grants.push_back(use_typed ? typed_grant : predicted);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int                  i;
        int                  r;
        int                  p;
        int                  k;
        int                  burst_left;
        bit                  quiet;
        logic                op;
        logic [15:0]         size;
        logic [4:0]          blocks_word;
        fpba_pkg::t_fit_mode phase_mode;

        for (i = 0; i < NUM_BLOCKS; i++)
            size_table[i] = '0;
        scan_ptr   = '0;
        mode_reg   = fpba_pkg::FIT_FIRST;
        blocks_reg = 5'(fpba_pkg::BLOCKS_RESET);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every entry gets written before any search
        for (i = 0; i < NUM_BLOCKS; i++)
            push_item(fpba_pkg::OP_LOAD, i[3:0], 16'((i + 1) * 100), 1'b0, NO_GRANT);

        for (r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_CFG: begin
                    drain(SETTLE_CYCLES);
                    write_reg(dir_rows[r].idx[0],
                              dir_rows[r].value[fpba_pkg::CFG_DATA_W-1:0]);
                end
                ROW_LOAD: push_item(fpba_pkg::OP_LOAD, dir_rows[r].idx, dir_rows[r].value,
                                    dir_rows[r].typed, dir_rows[r].res);
                default: push_item(fpba_pkg::OP_ALLOC, dir_rows[r].idx, dir_rows[r].value,
                                   dir_rows[r].typed, dir_rows[r].res);
            endcase
        end

        for (p = 0; p < PHASES; p++) begin
            quiet = (p == 2);
            case (p)
                0: blocks_word = 5'd16;
                1: blocks_word = 5'd5;
                2: blocks_word = 5'd16;
                3: blocks_word = 5'd1;
                4: blocks_word = 5'd12;
                5: blocks_word = 5'd16;
                6: blocks_word = 5'd3;
                default: blocks_word = 5'($urandom_range(1, 16));
            endcase
            phase_mode = (p == PHASES - 1) ? fpba_pkg::t_fit_mode'($urandom_range(0, 3))
                                           : fpba_pkg::t_fit_mode'(p % 4);
            drain(SETTLE_CYCLES);
            // upper data bits are don't-care for the mode register
            write_reg(fpba_pkg::CFG_FIT_MODE, {3'($urandom_range(0, 7)), phase_mode});
            write_reg(fpba_pkg::CFG_BLOCKS, blocks_word);
            stall_pct  = quiet ? 0 : $urandom_range(10, 60);
            burst_left = 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (burst_left == 0) begin
                    hold_input(quiet ? 0 : $urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (k == PHASE_ITEMS / 2 && (p == 4 || $urandom_range(0, 3) == 0))
                    drain(0);
                if ($urandom_range(0, 99) < 30) begin
                    op = fpba_pkg::OP_LOAD;
                    case ($urandom_range(0, 7))
                        0: size = 16'($urandom);
                        1: size = 16'h0000;
                        2: size = 16'hFFFF;
                        default: size = 16'($urandom_range(0, 2047));
                    endcase
                end else begin
                    op = fpba_pkg::OP_ALLOC;
                    case ($urandom_range(0, 7))
                        0: size = 16'($urandom);
                        1: size = 16'h0000;
                        default: size = 16'($urandom_range(1, 400));
                    endcase
                end
                push_item(op, 4'($urandom), size, 1'b0, NO_GRANT);
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
